### hw/rtl/cpsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsp_pkg
// Shared types, widths, limits and helpers for the cascaded position/speed
// PID unit.
// ----------------------------------------------------------------------------
package cpsp_pkg;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 16;
    localparam int DRIVE_W   = 8;
    localparam int SETPT_W   = 14;
    localparam int POS_W     = 32;
    localparam int ERR_W     = 32;
    localparam int DIFF_W    = 33;
    localparam int WIDE_W    = 41;
    localparam int SUM_W     = 46;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] PERIOD_RESET   = 10'd40;
    localparam logic [CFG_W-1:0] SPEED_KP_RESET = 10'd77;
    localparam logic [CFG_W-1:0] SPEED_KI_RESET = 10'd77;
    localparam logic [CFG_W-1:0] SPEED_KD_RESET = 10'd0;
    localparam logic [CFG_W-1:0] POS_KP_RESET   = 10'd77;
    localparam logic [CFG_W-1:0] POS_KI_RESET   = 10'd0;
    localparam logic [CFG_W-1:0] POS_KD_RESET   = 10'd102;

    // output limits: 100.0 and 20.0 in Q16.16
    localparam logic signed [SUM_W-1:0] DRIVE_LIM_Q16 = 46'sd6553600;
    localparam logic signed [SUM_W-1:0] SPEED_LIM_Q16 = 46'sd1310720;

    // limits as they show at the ports
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 8'sd100;
    localparam logic signed [SETPT_W-1:0] SETPT_MAX = 14'sd5120;

    localparam logic signed [WIDE_W-1:0] SAT_HI = 41'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -41'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD   = 3'd0,
        CFG_SPEED_KP = 3'd1,
        CFG_SPEED_KI = 3'd2,
        CFG_SPEED_KD = 3'd3,
        CFG_POS_KP   = 3'd4,
        CFG_POS_KI   = 3'd5,
        CFG_POS_KD   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] kp;
        logic [CFG_W-1:0] ki;
        logic [CFG_W-1:0] kd;
    } t_gains;

    // saturate a wide signed value to signed 32 bits
    function automatic logic signed [ERR_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [ERR_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[ERR_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[ERR_W-1:0];
        end else begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/cpsp_pid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsp_pid_core
// One positional PID pass: saturating integral, three gain products and
// their Q16.16 sum.
// ----------------------------------------------------------------------------
module cpsp_pid_core
    import cpsp_pkg::*;
(
    input  logic signed [ERR_W-1:0] i_err,
    input  logic signed [ERR_W-1:0] i_prev_err,
    input  logic signed [ERR_W-1:0] i_integ,
    input  t_gains                  i_gains,
    output logic signed [ERR_W-1:0] o_integ,
    output logic signed [SUM_W-1:0] o_sum
);

    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] integ_add;
    logic signed [ERR_W-1:0]  integ_sat;
    logic signed [CFG_W:0]    kp_s;
    logic signed [CFG_W:0]    ki_s;
    logic signed [CFG_W:0]    kd_s;
    logic signed [42:0]       err_x;
    logic signed [42:0]       integ_x;
    logic signed [43:0]       diff_x;
    logic signed [42:0]       p_kp;
    logic signed [42:0]       p_ki;
    logic signed [43:0]       p_kd;

    assign diff      = {i_err[ERR_W-1], i_err} - {i_prev_err[ERR_W-1], i_prev_err};
    assign integ_add = {i_integ[ERR_W-1], i_integ} + {i_err[ERR_W-1], i_err};
    assign integ_sat = sat32({{(WIDE_W-DIFF_W){integ_add[DIFF_W-1]}}, integ_add});

    // zero integral gain holds the integral at zero
    assign o_integ = (i_gains.ki == '0) ? '0 : integ_sat;

    assign kp_s    = {1'b0, i_gains.kp};
    assign ki_s    = {1'b0, i_gains.ki};
    assign kd_s    = {1'b0, i_gains.kd};
    assign err_x   = {{11{i_err[ERR_W-1]}}, i_err};
    assign integ_x = {{11{o_integ[ERR_W-1]}}, o_integ};
    assign diff_x  = {{11{diff[DIFF_W-1]}}, diff};

    assign p_kp = kp_s * err_x;
    assign p_ki = ki_s * integ_x;
    assign p_kd = kd_s * diff_x;

    assign o_sum = {{3{p_kp[42]}}, p_kp} + {{3{p_ki[42]}}, p_ki} + {{2{p_kd[43]}}, p_kd};

endmodule

### hw/rtl/cascaded_position_speed_pid_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_position_speed_pid_unit
// Tick divider with a cascaded position (outer) and speed (inner) PID loop.
// Each control step emits a drive command, the new speed setpoint and the
// accumulated position.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------------
//   input    | i_in_valid / o_in_stall    | i_encoder_delta, i_position_target
//   output   | o_out_valid / i_out_stall  | o_drive, o_speed_setpoint, o_position
//   config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one tick is taken every cycle unless a stalled result holds it; a step tick
// passes the input register, then one PID pass into the result register
// throughput is set by the single registered pass of both PID loops
// ticks that do not complete a divider period produce no transaction
// reset clears the divider, position, loop state and the result valid flag and
// loads the default gains; no clearing pass
// a stalled result freezes both stages and raises o_in_stall
// ----------------------------------------------------------------------------
module cascaded_position_speed_pid_unit
    import cpsp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // tick input
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [IN_W-1:0]    i_encoder_delta,
    input  logic signed [IN_W-1:0]    i_position_target,
    // step results
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DRIVE_W-1:0] o_drive,
    output logic signed [SETPT_W-1:0] o_speed_setpoint,
    output logic signed [POS_W-1:0]   o_position,
    // register writes
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    // configuration registers
    logic [CFG_W-1:0] r_period;
    t_gains           r_spd_gains;
    t_gains           r_pos_gains;

    // tick divider
    logic [CFG_W-1:0] r_tick_count;
    logic [CFG_W-1:0] tick_inc;
    logic [CFG_W-1:0] n_tick_count;
    logic             step;

    // pipeline control
    logic             en;
    logic             in_accept;
    logic             fire;

    // input register, holds step ticks only
    logic                   r_s1_valid;
    logic signed [IN_W-1:0] r_s1_delta;
    logic signed [IN_W-1:0] r_s1_target;

    // loop state
    logic signed [POS_W-1:0]   r_pos_acc;
    logic signed [SETPT_W-1:0] r_speed_target;
    logic signed [ERR_W-1:0]   r_spd_prev;
    logic signed [ERR_W-1:0]   r_spd_integ;
    logic signed [ERR_W-1:0]   r_pos_prev;
    logic signed [ERR_W-1:0]   r_pos_integ;

    // step datapath
    logic signed [POS_W-1:0]   n_pos_acc;
    logic signed [24:0]        spd_err_n;
    logic signed [ERR_W-1:0]   spd_err;
    logic signed [DIFF_W-1:0]  pos_diff;
    logic signed [ERR_W-1:0]   pos_err;
    logic signed [ERR_W-1:0]   n_spd_integ;
    logic signed [ERR_W-1:0]   n_pos_integ;
    logic signed [SUM_W-1:0]   spd_sum;
    logic signed [SUM_W-1:0]   pos_sum;
    logic signed [SUM_W-1:0]   spd_clamp;
    logic signed [SUM_W-1:0]   pos_clamp;
    logic signed [23:0]        drive_adj;
    logic signed [21:0]        setpt_adj;
    logic signed [DRIVE_W-1:0] n_drive;
    logic signed [SETPT_W-1:0] n_speed_target;

    // result register
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;
    logic signed [SETPT_W-1:0] r_setpt;
    logic signed [POS_W-1:0]   r_position;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign in_accept   = i_in_valid && en;
    assign fire        = en && r_s1_valid;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // configuration writes, indexes past the list are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period       <= PERIOD_RESET;
            r_spd_gains.kp <= SPEED_KP_RESET;
            r_spd_gains.ki <= SPEED_KI_RESET;
            r_spd_gains.kd <= SPEED_KD_RESET;
            r_pos_gains.kp <= POS_KP_RESET;
            r_pos_gains.ki <= POS_KI_RESET;
            r_pos_gains.kd <= POS_KD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD:   r_period       <= i_cfg_data;
                CFG_SPEED_KP: r_spd_gains.kp <= i_cfg_data;
                CFG_SPEED_KI: r_spd_gains.ki <= i_cfg_data;
                CFG_SPEED_KD: r_spd_gains.kd <= i_cfg_data;
                CFG_POS_KP:   r_pos_gains.kp <= i_cfg_data;
                CFG_POS_KI:   r_pos_gains.ki <= i_cfg_data;
                CFG_POS_KD:   r_pos_gains.kd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // tick divider: reaching or passing the period fires a step,
    // a period of zero fires on every tick
    // ------------------------------------------------------------------
    assign tick_inc     = r_tick_count + 10'd1;
    assign step         = !(tick_inc < r_period);
    assign n_tick_count = step ? '0 : tick_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
        end else if (in_accept) begin
            r_tick_count <= n_tick_count;
        end
    end

    // input register: only step ticks go on, others end here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= in_accept && step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_delta  <= i_encoder_delta;
            r_s1_target <= i_position_target;
        end
    end

    // ------------------------------------------------------------------
    // step datapath
    // ------------------------------------------------------------------
    // position accumulates modulo 2^32
    assign n_pos_acc = r_pos_acc + {{(POS_W-IN_W){r_s1_delta[IN_W-1]}}, r_s1_delta};

    // inner error: speed target minus delta in Q8.8, never leaves 25 bits
    assign spd_err_n = {{11{r_speed_target[SETPT_W-1]}}, r_speed_target}
                     - {r_s1_delta[IN_W-1], r_s1_delta, 8'h00};
    assign spd_err   = {{7{spd_err_n[24]}}, spd_err_n};

    // outer error: (target - position) in Q8.8, saturated to 32 bits
    assign pos_diff = {{(DIFF_W-IN_W){r_s1_target[IN_W-1]}}, r_s1_target}
                    - {n_pos_acc[POS_W-1], n_pos_acc};
    assign pos_err  = sat32({pos_diff, 8'h00});

    cpsp_pid_core u_spd_pid (
        .i_err      (spd_err),
        .i_prev_err (r_spd_prev),
        .i_integ    (r_spd_integ),
        .i_gains    (r_spd_gains),
        .o_integ    (n_spd_integ),
        .o_sum      (spd_sum)
    );

    cpsp_pid_core u_pos_pid (
        .i_err      (pos_err),
        .i_prev_err (r_pos_prev),
        .i_integ    (r_pos_integ),
        .i_gains    (r_pos_gains),
        .o_integ    (n_pos_integ),
        .o_sum      (pos_sum)
    );

    // clamp both loop outputs in Q16.16
    always_comb begin
        if (spd_sum > DRIVE_LIM_Q16) begin
            spd_clamp = DRIVE_LIM_Q16;
        end else if (spd_sum < -DRIVE_LIM_Q16) begin
            spd_clamp = -DRIVE_LIM_Q16;
        end else begin
            spd_clamp = spd_sum;
        end

        if (pos_sum > SPEED_LIM_Q16) begin
            pos_clamp = SPEED_LIM_Q16;
        end else if (pos_sum < -SPEED_LIM_Q16) begin
            pos_clamp = -SPEED_LIM_Q16;
        end else begin
            pos_clamp = pos_sum;
        end
    end

    // truncate toward zero: bias negative values before the shift
    assign drive_adj = spd_clamp[23:0] + (spd_clamp[SUM_W-1] ? 24'sh00FFFF : 24'sh000000);
    assign n_drive   = drive_adj[23:16];

    assign setpt_adj      = pos_clamp[21:0] + (pos_clamp[SUM_W-1] ? 22'sh0000FF : 22'sh000000);
    assign n_speed_target = setpt_adj[21:8];

    // loop state moves only on a step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_acc      <= '0;
            r_speed_target <= '0;
            r_spd_prev     <= '0;
            r_spd_integ    <= '0;
            r_pos_prev     <= '0;
            r_pos_integ    <= '0;
        end else if (fire) begin
            r_pos_acc      <= n_pos_acc;
            r_speed_target <= n_speed_target;
            r_spd_prev     <= spd_err;
            r_spd_integ    <= n_spd_integ;
            r_pos_prev     <= pos_err;
            r_pos_integ    <= n_pos_integ;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_drive    <= n_drive;
            r_setpt    <= n_speed_target;
            r_position <= n_pos_acc;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_drive          = r_drive;
    assign o_speed_setpoint = r_setpt;
    assign o_position       = r_position;

endmodule

### hw/rtl/cpsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsp_checker
// Port level checks for the cascaded position/speed PID unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module cpsp_checker
    import cpsp_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic signed [IN_W-1:0]    i_encoder_delta,
    input logic signed [IN_W-1:0]    i_position_target,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [DRIVE_W-1:0] o_drive,
    input logic signed [SETPT_W-1:0] o_speed_setpoint,
    input logic signed [POS_W-1:0]   o_position
);

    // a stalled result transaction stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_drive) && $stable(o_speed_setpoint)
             && $stable(o_position)))
        else $error("stalled result changed");

    // a stalled input transaction stays and holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=>
            (i_in_valid && $stable(i_encoder_delta) && $stable(i_position_target)))
        else $error("stalled input changed");

    // drive command stays inside its clamp
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive <= DRIVE_MAX && o_drive >= -DRIVE_MAX))
        else $error("drive out of range");

    // speed setpoint stays inside its clamp
    a_setpt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_speed_setpoint <= SETPT_MAX && o_speed_setpoint >= -SETPT_MAX))
        else $error("speed setpoint out of range");

    // the input side stalls only behind a blocked result
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

endmodule

bind cascaded_position_speed_pid_unit cpsp_checker u_cpsp_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cascaded position/speed PID unit. Ticks are
// pushed through the valid/stall input with bursts and gaps, results are
// taken under a stall pattern and compared field by field against a
// bit-accurate model of the divider, the inner speed loop and the outer
// position loop. Covers reset defaults, edge values, divider reprogramming,
// gain extremes, random register settings, back-pressure and saturation.
// ----------------------------------------------------------------------------
module tb
    import cpsp_pkg::*;
();

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    // result register follows the input register that the accepting edge loads
    localparam int RESULT_LATENCY = 1;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 2;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_TICKS    = 50;
    localparam int HOLD_CYCLES    = 300;
    localparam int LONG_TICKS     = 210;
    localparam int SAT_TICKS      = 300;

    localparam logic [CFG_W-1:0] LONG_PERIOD = 10'd100;

    localparam int SPEED_LOOP = 0;
    localparam int POS_LOOP   = 1;

    // register index past the end of the map, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam longint I32_MAX     = 64'sd2147483647;
    localparam longint I32_MIN     = -64'sd2147483648;
    localparam longint DRIVE_LIMIT = 64'sd6553600;   // 100.0 in Q16.16
    localparam longint SETPT_LIMIT = 64'sd1310720;   // 20.0 in Q16.16

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic signed [SETPT_W-1:0] setpoint;
        logic signed [POS_W-1:0]   position;
    } t_step_result;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } t_stall_mode;

    // dut connections, all inputs known from time zero
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic signed [IN_W-1:0]    in_delta  = '0;
    logic signed [IN_W-1:0]    in_target = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [DRIVE_W-1:0] out_drive;
    logic signed [SETPT_W-1:0] out_setpoint;
    logic signed [POS_W-1:0]   out_position;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data  = '0;

    // shadow of the register file, starts at the reset values
    logic [CFG_W-1:0] cfg_period  = PERIOD_RESET;
    t_gains           speed_gains = {SPEED_KP_RESET, SPEED_KI_RESET, SPEED_KD_RESET};
    t_gains           pos_gains   = {POS_KP_RESET, POS_KI_RESET, POS_KD_RESET};

    // controller state as the model tracks it
    logic [CFG_W-1:0] pred_ticks        = '0;
    logic [POS_W-1:0] pred_position     = '0;
    longint           pred_speed_target = 0;
    longint           loop_prev_err [2] = '{0, 0};
    longint           loop_integral [2] = '{0, 0};

    // control steps predicted but not yet seen at the output
    t_step_result pending_steps [$];

    // traffic shaping
    t_stall_mode stall_mode    = STALL_NONE;
    int          idle_max      = 0;
    int          burst_left    = 0;
    int          hold_left     = 0;
    logic [15:0] stall_pattern = '0;
    logic [3:0]  pattern_pos   = '0;

    int mismatches    = 0;
    int steps_checked = 0;
    int ticks_sent    = 0;
    int reg_writes    = 0;
    int cycle_count   = 0;

    cascaded_position_speed_pid_unit i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_encoder_delta   (in_delta),
        .i_position_target (in_target),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_drive           (out_drive),
        .o_speed_setpoint  (out_setpoint),
        .o_position        (out_position),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // controller model
    // ------------------------------------------------------------------

    function automatic longint clip_i32(input longint v);
        if (v > I32_MAX) return I32_MAX;
        if (v < I32_MIN) return I32_MIN;
        return v;
    endfunction

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // arithmetic shift that rounds toward zero instead of toward minus infinity
    function automatic longint shift_to_zero(input longint v, input int sh);
        if (v < 0) return -((-v) >>> sh);
        return v >>> sh;
    endfunction

    // positional pid, returns the q16.16 sum and updates the loop state
    function automatic longint loop_pass(input int loop, input longint err, input t_gains g);
        longint diff;
        diff = err - loop_prev_err[loop];
        loop_prev_err[loop] = err;
        if (g.ki != '0) begin
            loop_integral[loop] = clip_i32(loop_integral[loop] + err);
        end else begin
            loop_integral[loop] = 0;
        end
        return longint'(g.kp) * err + longint'(g.ki) * loop_integral[loop]
               + longint'(g.kd) * diff;
    endfunction

    // advance the divider by one tick; on a control step queue the result
    function automatic void step_controller(input logic signed [IN_W-1:0] delta,
                                            input logic signed [IN_W-1:0] target);
        longint       pos;
        longint       err;
        longint       sum;
        t_step_result res;
        pred_ticks = pred_ticks + 1'b1;
        if (pred_ticks < cfg_period) return;
        pred_ticks = '0;

        pred_position = pred_position + {{(POS_W-IN_W){delta[IN_W-1]}}, delta};
        pos = $signed(pred_position);

        // inner loop: stored speed target against the measured delta
        err = clip_i32(pred_speed_target - longint'(delta) * 256);
        sum = clamp_sym(loop_pass(SPEED_LOOP, err, speed_gains), DRIVE_LIMIT);
        res.drive = DRIVE_W'(shift_to_zero(sum, 16));

        // outer loop: position target against the accumulated position
        err = clip_i32((longint'(target) - pos) * 256);
        sum = clamp_sym(loop_pass(POS_LOOP, err, pos_gains), SETPT_LIMIT);
        pred_speed_target = shift_to_zero(sum, 8);
        res.setpoint = SETPT_W'(pred_speed_target);
        res.position = pred_position;
        pending_steps.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // random picks
    // ------------------------------------------------------------------

    function automatic logic [CFG_W-1:0] random_gain();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return CFG_W'($urandom_range(1, 128));
            default:    return CFG_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // mostly short periods so that steps are frequent
    function automatic logic [CFG_W-1:0] random_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_W'($urandom_range(7, 40));
            default: return CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic signed [IN_W-1:0] random_delta();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return IN_W'($urandom_range(0, 400) - 200);
            4, 5:       return IN_W'($urandom());
            6: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7fff;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default:    return IN_W'($urandom_range(0, 4000) - 2000);
        endcase
    endfunction

    // half of the targets sit close to the position so the loops stay linear
    function automatic logic signed [IN_W-1:0] random_target();
        if ($urandom_range(0, 1) == 0) begin
            return IN_W'(pred_position + $urandom_range(0, 400) - 200);
        end
        return IN_W'($urandom());
    endfunction

    function automatic t_gains gains(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ki,
                                     input logic [CFG_W-1:0] kd);
        t_gains g;
        g.kp = kp;
        g.ki = ki;
        g.kd = kd;
        return g;
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_PERIOD:   cfg_period     = data;
            CFG_SPEED_KP: speed_gains.kp = data;
            CFG_SPEED_KI: speed_gains.ki = data;
            CFG_SPEED_KD: speed_gains.kd = data;
            CFG_POS_KP:   pos_gains.kp   = data;
            CFG_POS_KI:   pos_gains.ki   = data;
            CFG_POS_KD:   pos_gains.kd   = data;
            default:      ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic program_all(input logic [CFG_W-1:0] period, input t_gains sg,
                               input t_gains pg);
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_SPEED_KP, sg.kp);
        write_reg(CFG_SPEED_KI, sg.ki);
        write_reg(CFG_SPEED_KD, sg.kd);
        write_reg(CFG_POS_KP, pg.kp);
        write_reg(CFG_POS_KI, pg.ki);
        write_reg(CFG_POS_KD, pg.kd);
    endtask

    // changed on a rising edge so the stall process never races it
    task automatic set_traffic(input t_stall_mode mode, input int idle, input int hold);
        @(posedge clk);
        stall_mode = mode;
        idle_max   = idle;
        hold_left  = hold;
        burst_left = 0;
    endtask

    // one tick transaction; valid stays up within a burst
    task automatic send_tick(input logic signed [IN_W-1:0] delta,
                             input logic signed [IN_W-1:0] target);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
            if (gap > 0) begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid  = 1'b1;
        in_delta  = delta;
        in_target = target;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        step_controller(delta, target);
        ticks_sent++;
    endtask

    // sender goes quiet until every predicted step is out, then lets the
    // pipeline settle so a tick still in flight cannot meet a register write
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_steps.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver stall: long hold-off first, then the selected pattern
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else begin
            case (stall_mode)
                STALL_NONE:   out_stall = 1'b0;
                STALL_RANDOM: out_stall = ($urandom_range(0, 99) < 35);
                default: begin
                    if (pattern_pos == '0) stall_pattern = 16'($urandom());
                    out_stall = stall_pattern[pattern_pos];
                    pattern_pos = pattern_pos + 1'b1;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk) begin : check_step
        t_step_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_steps.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected step result, actual drive %0d setpoint %0d position %0d",
                         $time, out_drive, out_setpoint, out_position);
            end else begin
                want = pending_steps.pop_front();
                check_field("drive", $signed(want.drive), out_drive);
                check_field("speed_setpoint", $signed(want.setpoint), out_setpoint);
                check_field("position", $signed(want.position), out_position);
                steps_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset register values: two full periods of the default divider
    task automatic test_reset_defaults();
        set_traffic(STALL_RANDOM, 3, 0);
        repeat (2 * PERIOD_RESET) send_tick(random_delta(), random_target());
        drain();
    endtask

    // field extremes and alternating bit patterns, a step on every tick
    task automatic test_edge_values();
        program_all('0, gains(10'd77, 10'd77, 10'd0), gains(10'd77, 10'd0, 10'd102));
        set_traffic(STALL_PATTERN, 2, 0);
        send_tick(16'sh0000, 16'sh0000);
        send_tick(16'sh7fff, 16'sh7fff);
        send_tick(16'sh8000, 16'sh8000);
        send_tick(16'sh7fff, 16'sh8000);
        send_tick(16'sh8000, 16'sh7fff);
        send_tick(16'shffff, 16'shffff);
        send_tick(16'sh0001, 16'sh0001);
        send_tick(16'shffff, 16'sh0000);
        send_tick(16'sh0000, 16'shffff);
        send_tick(16'sh5555, 16'shaaaa);
        send_tick(16'shaaaa, 16'sh5555);
        send_tick(16'sh0003, 16'shfffd);
        send_tick(16'sh7fff, 16'sh0000);
        send_tick(16'sh8000, 16'sh0000);
        drain();
    endtask

    // period lowered below the running count, spare index, a long period
    task automatic test_divider();
        write_reg(CFG_PERIOD, 10'd40);
        set_traffic(STALL_RANDOM, 4, 0);
        repeat (10) send_tick(random_delta(), random_target());
        drain();
        // count is past the new period, so the next tick steps
        write_reg(CFG_PERIOD, 10'd3);
        repeat (7) send_tick(random_delta(), random_target());
        drain();
        // must not touch the period or any gain
        write_reg(CFG_SPARE, 10'd1);
        repeat (6) send_tick(random_delta(), random_target());
        drain();
        write_reg(CFG_PERIOD, LONG_PERIOD);
        set_traffic(STALL_NONE, 0, 0);
        repeat (LONG_TICKS) send_tick(random_delta(), random_target());
        drain();
    endtask

    // full-scale gains, integral clear on zero ki, all gains zero
    task automatic test_gain_extremes();
        program_all('0, gains('1, '1, '1), gains('1, '1, '1));
        set_traffic(STALL_RANDOM, 2, 0);
        repeat (20) send_tick(random_delta(), random_target());
        drain();
        write_reg(CFG_SPEED_KI, '0);
        write_reg(CFG_POS_KI, '0);
        repeat (8) send_tick(random_delta(), random_target());
        drain();
        program_all(10'd1, gains('0, '0, '0), gains('0, '0, '0));
        repeat (6) send_tick(random_delta(), random_target());
        drain();
    endtask

    // random register settings and traffic, one sender pause mid run
    task automatic test_random_phases();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            program_all(random_period(), gains(random_gain(), random_gain(), random_gain()),
                        gains(random_gain(), random_gain(), random_gain()));
            set_traffic(t_stall_mode'($urandom_range(0, 2)), $urandom_range(0, 2) * 4, 0);
            for (int i = 0; i < PHASE_TICKS; i++) begin
                send_tick(random_delta(), random_target());
                if (phase == RANDOM_PHASES / 2 && i == PHASE_TICKS / 2) drain();
            end
            drain();
        end
    endtask

    // receiver holds off while ticks keep coming, so the unit backs up
    task automatic test_backpressure();
        program_all('0, gains(10'd77, 10'd77, 10'd0), gains(10'd77, 10'd0, 10'd102));
        set_traffic(STALL_NONE, 0, HOLD_CYCLES);
        repeat (60) send_tick(random_delta(), random_target());
        drain();
    endtask

    // full-scale deltas away from zero; the outer error and both integrals
    // run into their 32 bit limits
    task automatic test_saturation();
        logic go_down;
        program_all(10'd1, gains(CFG_W'($urandom_range(1, 1023)), 10'd300,
                                 CFG_W'($urandom_range(0, 1023))),
                    gains(CFG_W'($urandom_range(1, 1023)), 10'd300,
                          CFG_W'($urandom_range(0, 1023))));
        set_traffic(STALL_NONE, 0, 0);
        go_down = pred_position[POS_W-1];
        repeat (SAT_TICKS) send_tick(go_down ? 16'sh8000 : 16'sh7fff, random_target());
        drain();
    endtask

    // ------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached with %0d steps outstanding", $time,
                 pending_steps.size());
        $display("tb failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_edge_values();
        test_divider();
        test_gain_extremes();
        test_random_phases();
        test_backpressure();
        test_saturation();

        $display("sent %0d ticks, checked %0d control steps, %0d register writes",
                 ticks_sent, steps_checked, reg_writes);
        $display("covered divider limits, gain extremes, receiver hold-off and saturation");
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
